[hw/rtl/kvt_pkg.sv]
// shared types, codes and defaults for the key/value table
`default_nettype none
package kvt_pkg;

  localparam int ENTRIES_DEF     = 8;
  localparam int NAME_BYTES_DEF  = 8;
  localparam int VALUE_BYTES_DEF = 8;

  // port widths fixed by the request and result formats
  localparam int ACT_W  = 2;
  localparam int ST_W   = 2;
  localparam int WORD_W = 64;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam action_t ACT_FIND  = 2'd0;
  localparam action_t ACT_SET   = 2'd1;
  localparam action_t ACT_UNSET = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOTFOUND = 2'd1;
  localparam status_t ST_FULL     = 2'd2;

endpackage
`default_nettype wire

[hw/rtl/key_value_table.sv]
// key_value_table: small associative table of named entries
//
// Requests come in on the in_ channel (action, key_name, value_in) and one
// result per request leaves on the out_ channel (status, value_out). Both
// channels move a request when valid is high and stall is low.
// Find returns the value of the matching used entry, set overwrites a
// matching entry or claims the lowest free slot, unset frees the match.
// Names and values sit in two synchronous memories with one read port
// each; used flags sit in flip-flops.
// Each request passes the idle state, which takes it and issues the first
// read, then the scan, which compares one slot per cycle against the
// registered read data, and last the write-back state, which writes the
// memories and used flags and loads the result register.
// The result stays in an output register, so a new request is taken while
// an earlier result still waits. When the receiver stalls and the output
// register is still full, the write-back cycle waits for it.
// Reset (rst_n low, synchronous) empties the table at once by clearing the
// used flags and drops any pending result; no clearing pass is needed.
`default_nettype none
module key_value_table #(
  parameter int ENTRIES     = kvt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES  = kvt_pkg::NAME_BYTES_DEF,
  parameter int VALUE_BYTES = kvt_pkg::VALUE_BYTES_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire kvt_pkg::action_t       in_action,
  input  wire [kvt_pkg::WORD_W-1:0]   in_key_name,
  input  wire [kvt_pkg::WORD_W-1:0]   in_value_in,
  output logic                        out_valid,
  input  wire                         out_stall,
  output kvt_pkg::status_t            out_status,
  output logic [kvt_pkg::WORD_W-1:0]  out_value_out
);

  localparam int NAME_W  = NAME_BYTES * 8;
  localparam int VALUE_W = VALUE_BYTES * 8;
  localparam int IDXW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [IDXW-1:0]    cmp_idx_r, cmp_idx_nxt;
  kvt_pkg::action_t   act_r, act_nxt;
  logic [NAME_W-1:0]  key_r, key_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic               hit_r, hit_nxt;
  logic [IDXW-1:0]    hit_idx_r, hit_idx_nxt;
  logic [VALUE_W-1:0] hit_val_r, hit_val_nxt;
  logic               free_r, free_nxt;
  logic [IDXW-1:0]    free_idx_r, free_idx_nxt;
  logic [ENTRIES-1:0] used_r, used_nxt;

  logic                       out_valid_r, out_valid_nxt;
  kvt_pkg::status_t           out_status_r, out_status_nxt;
  logic [kvt_pkg::WORD_W-1:0] out_value_r, out_value_nxt;

  logic [NAME_W-1:0]  name_mem  [ENTRIES];
  logic [VALUE_W-1:0] value_mem [ENTRIES];
  logic [NAME_W-1:0]  name_rd_r;
  logic [VALUE_W-1:0] value_rd_r;

  logic [IDXW-1:0]    rd_addr;
  logic               in_fire;
  logic               fin_fire;
  logic               out_room;
  logic               cur_used;
  logic               cur_match;
  logic               name_we;
  logic               value_we;
  logic [IDXW-1:0]    wr_idx;

  assign in_stall      = (state_r != S_IDLE);
  assign in_fire       = in_valid && !in_stall;
  assign out_room      = !out_valid_r || !out_stall;
  assign fin_fire      = (state_r == S_FIN) && out_room;
  assign cur_used      = used_r[cmp_idx_r];
  assign cur_match     = cur_used && (name_rd_r == key_r);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

  // read one slot ahead of the compare
  always_comb begin
    if (state_r == S_IDLE || cmp_idx_r == LAST_IDX) begin
      rd_addr = '0;
    end else begin
      rd_addr = cmp_idx_r + IDXW'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmp_idx_nxt    = cmp_idx_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_val_nxt    = hit_val_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    name_we        = 1'b0;
    value_we       = 1'b0;
    wr_idx         = hit_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt     = in_action;
          key_nxt     = in_key_name[NAME_W-1:0];
          val_nxt     = in_value_in[VALUE_W-1:0];
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          cmp_idx_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        // lowest matching slot and lowest free slot
        if (!hit_r && cur_match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_val_nxt = value_rd_r;
        end
        if (!free_r && !cur_used) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (cmp_idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          cmp_idx_nxt = cmp_idx_r + IDXW'(1);
        end
      end
      S_FIN: begin
        if (out_room) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = kvt_pkg::ST_NOTFOUND;
          out_value_nxt  = '0;
          unique case (act_r)
            kvt_pkg::ACT_FIND: begin
              if (hit_r) begin
                out_status_nxt = kvt_pkg::ST_OK;
                out_value_nxt  = kvt_pkg::WORD_W'(hit_val_r);
              end
            end
            kvt_pkg::ACT_SET: begin
              if (hit_r) begin
                value_we       = 1'b1;
                out_status_nxt = kvt_pkg::ST_OK;
              end else if (free_r) begin
                wr_idx           = free_idx_r;
                name_we          = 1'b1;
                value_we         = 1'b1;
                used_nxt[free_idx_r] = 1'b1;
                out_status_nxt   = kvt_pkg::ST_OK;
              end else begin
                out_status_nxt = kvt_pkg::ST_FULL;
              end
            end
            kvt_pkg::ACT_UNSET: begin
              if (hit_r) begin
                used_nxt[hit_idx_r] = 1'b0;
                out_status_nxt      = kvt_pkg::ST_OK;
              end
            end
            default: begin
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[wr_idx] <= key_r;
    end
    if (value_we) begin
      value_mem[wr_idx] <= val_r;
    end
    name_rd_r  <= name_mem[rd_addr];
    value_rd_r <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_idx_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_val_r    <= hit_val_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |=> out_valid_r)
    else $error("write-back did not load the result register");

  a_value_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != kvt_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("non-zero value on a failed request");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire && (out_status_nxt == kvt_pkg::ST_FULL) |-> (&used_r))
    else $error("table full reported with a free slot");

  a_hit_is_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && hit_r |-> used_r[hit_idx_r])
    else $error("match recorded on a free slot");

  a_free_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && free_r |-> !used_r[free_idx_r])
    else $error("free slot recorded on a used slot");

endmodule
`default_nettype wire

[verif/tb.sv]
// testbench for key_value_table: directed and random find/set/unset requests and unknown actions
module tb;

  localparam int      ENTRIES     = kvt_pkg::ENTRIES_DEF;
  localparam int      WORD_W      = kvt_pkg::WORD_W;
  localparam int      QUIET_LIMIT = 2000;
  // the block treats the spare action code as an unknown request
  localparam kvt_pkg::action_t ACT_BAD = 2'd3;

  typedef struct {
    kvt_pkg::status_t   status;
    logic [WORD_W-1:0]  value;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  kvt_pkg::action_t   in_action = kvt_pkg::ACT_FIND;
  logic [WORD_W-1:0]  in_key_name = '0;
  logic [WORD_W-1:0]  in_value_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  kvt_pkg::status_t   out_status;
  logic [WORD_W-1:0]  out_value_out;

  // our own copy of the table
  logic               table_used [ENTRIES];
  logic [WORD_W-1:0]  table_name [ENTRIES];
  logic [WORD_W-1:0]  table_value [ENTRIES];

  answer_t            pending_answers [$];
  logic [WORD_W-1:0]  key_pool [12];
  int                 error_count = 0;
  int                 quiet_cycles = 0;
  int                 stall_left = 0;
  bit                 idle_on = 1'b1;

  key_value_table i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_key_name   (in_key_name),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value_out (out_value_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] low_bytes(input logic [WORD_W-1:0] w, input int n);
    return (n >= 8) ? w : (w & ((64'd1 << (8 * n)) - 64'd1));
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // applies one request to the table copy and returns what the block should answer
  function automatic answer_t table_update(input kvt_pkg::action_t act,
                                           input logic [WORD_W-1:0] key_raw,
                                           input logic [WORD_W-1:0] val_raw);
    answer_t            ans;
    logic [WORD_W-1:0]  key;
    logic [WORD_W-1:0]  val;
    int                 hit;
    int                 free_idx;
    key = low_bytes(key_raw, kvt_pkg::NAME_BYTES_DEF);
    val = low_bytes(val_raw, kvt_pkg::VALUE_BYTES_DEF);
    ans.status = kvt_pkg::ST_NOTFOUND;
    ans.value = '0;
    hit = -1;
    free_idx = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (table_used[i] && table_name[i] == key) hit = i;
      if (!table_used[i]) free_idx = i;
    end
    case (act)
      kvt_pkg::ACT_FIND: begin
        if (hit >= 0) begin
          ans.status = kvt_pkg::ST_OK;
          ans.value = table_value[hit];
        end
      end
      kvt_pkg::ACT_SET: begin
        if (hit >= 0) begin
          table_value[hit] = val;
          ans.status = kvt_pkg::ST_OK;
        end else if (free_idx >= 0) begin
          table_name[free_idx] = key;
          table_value[free_idx] = val;
          table_used[free_idx] = 1'b1;
          ans.status = kvt_pkg::ST_OK;
        end else begin
          ans.status = kvt_pkg::ST_FULL;
        end
      end
      kvt_pkg::ACT_UNSET: begin
        if (hit >= 0) begin
          table_used[hit] = 1'b0;
          ans.status = kvt_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic send_request(input kvt_pkg::action_t act, input logic [WORD_W-1:0] key,
                              input logic [WORD_W-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key_name <= key;
    in_value_in <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(table_update(act, key, val));
  endtask

  // random requests; weights in percent, the rest are finds and a few unknown actions
  task automatic run_mix(input int count, input int set_pct, input int unset_pct,
                         input int noise_pct);
    int                 r;
    kvt_pkg::action_t   act;
    logic [WORD_W-1:0]  key;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 4) act = ACT_BAD;
      else if (r < 4 + set_pct) act = kvt_pkg::ACT_SET;
      else if (r < 4 + set_pct + unset_pct) act = kvt_pkg::ACT_UNSET;
      else act = kvt_pkg::ACT_FIND;
      if ($urandom_range(0, 99) < noise_pct) key = rand_word();
      else key = key_pool[$urandom_range(0, 11)];
      send_request(act, key, rand_word());
    end
  endtask

  task automatic test_directed();
    send_request(kvt_pkg::ACT_FIND, '0, '0);
    send_request(kvt_pkg::ACT_UNSET, '0, '1);
    send_request(ACT_BAD, '0, '1);
    send_request(kvt_pkg::ACT_SET, '0, '1);
    send_request(kvt_pkg::ACT_FIND, '0, '0);
    send_request(kvt_pkg::ACT_SET, '1, '0);
    send_request(kvt_pkg::ACT_FIND, '1, '1);
    send_request(kvt_pkg::ACT_SET, '0, 64'h0123_4567_89ab_cdef);
    send_request(kvt_pkg::ACT_FIND, '0, '0);
    // key one bit away from a stored one must miss
    send_request(kvt_pkg::ACT_FIND, 64'd1, '0);
    for (int k = 2; k < 8; k++) send_request(kvt_pkg::ACT_SET, key_pool[k], rand_word());
    send_request(kvt_pkg::ACT_SET, key_pool[8], rand_word());
    send_request(kvt_pkg::ACT_SET, key_pool[2], 64'hfedc_ba98_7654_3210);
    send_request(kvt_pkg::ACT_FIND, key_pool[2], '0);
    // free a middle slot and reclaim it
    send_request(kvt_pkg::ACT_UNSET, '1, '0);
    send_request(kvt_pkg::ACT_SET, key_pool[8], rand_word());
    send_request(kvt_pkg::ACT_FIND, key_pool[8], '0);
    send_request(kvt_pkg::ACT_UNSET, '0, '0);
    send_request(kvt_pkg::ACT_UNSET, '0, '0);
    send_request(ACT_BAD, key_pool[2], '1);
  endtask

  task automatic test_fill_heavy();
    idle_on = 1'b1;
    run_mix(400, 60, 15, 5);
  endtask

  task automatic test_drain_heavy();
    run_mix(400, 15, 60, 5);
  endtask

  task automatic test_noisy_keys();
    run_mix(400, 35, 25, 40);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_mix(500, 40, 30, 5);
  endtask

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    answer_t exp_ans;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: status %0d, value_out %h", out_status, out_value_out);
        error_count++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_status !== exp_ans.status) begin
          $error("status: expected %0d, got %0d", exp_ans.status, out_status);
          error_count++;
        end
        if (out_value_out !== exp_ans.value) begin
          $error("value_out: expected %h, got %h", exp_ans.value, out_value_out);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("key_value_table: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      table_used[i] = 1'b0;
      table_name[i] = '0;
      table_value[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < 8; k++) key_pool[k] = rand_word();
    // near misses of one stored key
    for (int k = 8; k < 12; k++) key_pool[k] = key_pool[2] ^ (64'd1 << $urandom_range(0, 63));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_heavy();
    test_drain_heavy();
    test_noisy_keys();
    test_back_to_back();
    in_valid <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (ENTRIES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("key_value_table: match");
    end else begin
      $display("key_value_table: mismatch");
    end
    $finish;
  end

endmodule
